// ===== rtl/bpid_pkg.sv =====
// Shared types, widths and constants for the cascaded balance controller.
`default_nettype none

package bpid_pkg;

    localparam int INT_W              = 14;
    localparam int INTEGRAL_LIMIT_DEF = 4210;
    localparam int TILT_LIMIT_Q8      = 12800;
    localparam int GAIN_W             = 24;
    localparam int TERM_W             = 32;
    localparam int SUM_W              = 34;

    localparam logic [GAIN_W-1:0] BALANCE_KP_RST    = 24'd1517568;
    localparam logic [GAIN_W-1:0] BALANCE_KD_RST    = 24'd5304;
    localparam logic [16:0]       ROLL_SETPOINT_RST = 17'd461;
    localparam logic [GAIN_W-1:0] SPEED_KP_RST      = 24'd360448;
    localparam logic [GAIN_W-1:0] SPEED_KI_RST      = 24'd1556;
    localparam logic [GAIN_W-1:0] TURN_KP_RST       = 24'd360448;
    localparam logic [GAIN_W-1:0] TURN_KI_RST       = 24'd1556;
    localparam logic [14:0]       PWM_LIMIT_RST     = 15'd7200;

    localparam logic [2:0] REG_BALANCE_KP    = 3'd0;
    localparam logic [2:0] REG_BALANCE_KD    = 3'd1;
    localparam logic [2:0] REG_ROLL_SETPOINT = 3'd2;
    localparam logic [2:0] REG_SPEED_KP      = 3'd3;
    localparam logic [2:0] REG_SPEED_KI      = 3'd4;
    localparam logic [2:0] REG_TURN_KP       = 3'd5;
    localparam logic [2:0] REG_TURN_KI       = 3'd6;
    localparam logic [2:0] REG_PWM_LIMIT     = 3'd7;

    typedef struct packed {
        logic [GAIN_W-1:0] balance_kp;
        logic [GAIN_W-1:0] balance_kd;
        logic signed [16:0] roll_setpoint;
        logic [GAIN_W-1:0] speed_kp;
        logic [GAIN_W-1:0] speed_ki;
        logic [GAIN_W-1:0] turn_kp;
        logic [GAIN_W-1:0] turn_ki;
        logic [14:0]       pwm_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [16:0] filtered_roll;
        logic signed [15:0] gyro_rate;
        logic signed [15:0] left_count;
        logic signed [15:0] right_count;
        logic signed [7:0]  target_speed;
        logic signed [7:0]  turn_command;
    } sample_t;

    typedef struct packed {
        logic signed [17:0]      roll_err;
        logic signed [16:0]      gyro_neg;
        logic signed [16:0]      spd_err_a;
        logic signed [16:0]      spd_err_b;
        logic signed [17:0]      trn_err;
        logic signed [INT_W-1:0] spd_int_a;
        logic signed [INT_W-1:0] spd_int_b;
        logic signed [INT_W-1:0] trn_int_a;
        logic signed [INT_W-1:0] trn_int_b;
        logic                    trip;
    } err_t;

    typedef struct packed {
        logic signed [42:0] bal_p;
        logic signed [41:0] bal_d;
        logic signed [41:0] spd_p_a;
        logic signed [41:0] spd_p_b;
        logic signed [38:0] spd_i_a;
        logic signed [38:0] spd_i_b;
        logic signed [42:0] trn_p;
        logic signed [38:0] trn_i_a;
        logic signed [38:0] trn_i_b;
        logic               trip;
    } prod_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] bal;
        logic signed [TERM_W-1:0] va;
        logic signed [TERM_W-1:0] vb;
        logic signed [TERM_W-1:0] ta;
        logic signed [TERM_W-1:0] tb;
        logic                     trip;
    } terms_t;

endpackage

`default_nettype wire

// ===== rtl/balance_robot_cascaded_pid_top.sv =====
// Cascaded balance / speed / turn controller for a two-wheel robot, top level.
//
// One control tick enters on the input channel (in_valid / in_ready) with
// roll, gyro rate, both encoder counts, target speed and turn command.
// One result leaves on the output channel (out_valid / out_ready) with both
// motor drives and the tilt trip flag.
// The datapath is a five-register pipeline: input register, error and
// integrator stage, gain multipliers, term rescaling, drive clamp. One tick
// is taken every cycle while in_ready is high; the integrators close their
// loop inside a single stage, so consecutive ticks never wait on each other.
// When the receiver stalls, the output register holds and each stage keeps
// taking items until the pipeline is full; in_ready drops only then.
// Gains, setpoint and drive limit are written on cfg_we / cfg_index /
// cfg_data; the user must write them only while the block is idle, which
// the block itself does not enforce. Reset empties the pipeline, loads the
// default gains and clears both integrators.
`default_nettype none

module balance_robot_cascaded_pid_top
    import bpid_pkg::*;
#(
    parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [16:0] filtered_roll,
    input  wire logic signed [15:0] gyro_rate,
    input  wire logic signed [15:0] left_count,
    input  wire logic signed [15:0] right_count,
    input  wire logic signed [7:0]  target_speed,
    input  wire logic signed [7:0]  turn_command,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      drive_a,
    output logic signed [15:0]      drive_b,
    output logic                    tilt_trip
);

    cfg_t    cfg;
    sample_t smp_reg;
    err_t    err;
    prod_t   prod;
    terms_t  terms;

    // Stage valids: 1 input reg, 2 integrators, 3 products, 4 terms, 5 output
    logic [5:1] vld_reg;
    logic [5:1] vld_next;
    logic [6:1] en;
    logic [5:1] load;

    always_comb
    begin
        en[6] = out_ready;
        for (int k = 5; k >= 1; k--)
            en[k] = !vld_reg[k] || en[k+1];
        load[1] = en[1] && in_valid;
        for (int k = 2; k <= 5; k++)
            load[k] = en[k] && vld_reg[k-1];
        vld_next = vld_reg;
        vld_next[1] = en[1] ? in_valid : vld_reg[1];
        for (int k = 2; k <= 5; k++)
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            smp_reg.filtered_roll <= filtered_roll;
            smp_reg.gyro_rate     <= gyro_rate;
            smp_reg.left_count    <= left_count;
            smp_reg.right_count   <= right_count;
            smp_reg.target_speed  <= target_speed;
            smp_reg.turn_command  <= turn_command;
        end
    end

    bpid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpid_integ #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_integ (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load[2]),
        .cfg   (cfg),
        .smp   (smp_reg),
        .err   (err)
    );

    bpid_mul u_mul (
        .clk  (clk),
        .load (load[3]),
        .cfg  (cfg),
        .err  (err),
        .prod (prod)
    );

    bpid_terms u_terms (
        .clk   (clk),
        .load  (load[4]),
        .prod  (prod),
        .terms (terms)
    );

    bpid_drive u_drive (
        .clk       (clk),
        .load      (load[5]),
        .cfg       (cfg),
        .terms     (terms),
        .drive_a   (drive_a),
        .drive_b   (drive_b),
        .tilt_trip (tilt_trip)
    );

    assign in_ready  = en[1];
    assign out_valid = vld_reg[5];

endmodule

`default_nettype wire

// ===== rtl/bpid_cfg.sv =====
// Configuration register file for gains, setpoint and drive limit.
`default_nettype none

module bpid_cfg
    import bpid_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BALANCE_KP:    cfg_next.balance_kp    = cfg_data;
                REG_BALANCE_KD:    cfg_next.balance_kd    = cfg_data;
                REG_ROLL_SETPOINT: cfg_next.roll_setpoint = $signed(cfg_data[16:0]);
                REG_SPEED_KP:      cfg_next.speed_kp      = cfg_data;
                REG_SPEED_KI:      cfg_next.speed_ki      = cfg_data;
                REG_TURN_KP:       cfg_next.turn_kp       = cfg_data;
                REG_TURN_KI:       cfg_next.turn_ki       = cfg_data;
                REG_PWM_LIMIT:     cfg_next.pwm_limit     = cfg_data[14:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.balance_kp    <= BALANCE_KP_RST;
            cfg_reg.balance_kd    <= BALANCE_KD_RST;
            cfg_reg.roll_setpoint <= $signed(ROLL_SETPOINT_RST);
            cfg_reg.speed_kp      <= SPEED_KP_RST;
            cfg_reg.speed_ki      <= SPEED_KI_RST;
            cfg_reg.turn_kp       <= TURN_KP_RST;
            cfg_reg.turn_ki       <= TURN_KI_RST;
            cfg_reg.pwm_limit     <= PWM_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/bpid_integ.sv =====
// Error formation and the two clamped integrators, each advanced twice per tick.
`default_nettype none

module bpid_integ
    import bpid_pkg::*;
#(
    parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire cfg_t    cfg,
    input  wire sample_t smp,
    output err_t         err
);

    localparam logic signed [18:0] LIM_POS = 19'(INTEGRAL_LIMIT);
    localparam logic signed [18:0] LIM_NEG = -19'(INTEGRAL_LIMIT);

    logic signed [INT_W-1:0] spd_int_reg;
    logic signed [INT_W-1:0] trn_int_reg;
    err_t                    err_reg;
    err_t                    err_next;

    logic signed [18:0] spd_sum_a;
    logic signed [18:0] spd_sum_b;
    logic signed [18:0] trn_sum_a;
    logic signed [18:0] trn_sum_b;

    function automatic logic signed [INT_W-1:0] clamp_int(input logic signed [18:0] v);
        logic signed [18:0] r;
        begin
            r = v;
            if (v > LIM_POS)
                r = LIM_POS;
            else if (v < LIM_NEG)
                r = LIM_NEG;
            clamp_int = INT_W'(r);
        end
    endfunction

    always_comb
    begin
        err_next.roll_err  = 18'(cfg.roll_setpoint) - 18'(smp.filtered_roll);
        err_next.gyro_neg  = -17'(smp.gyro_rate);
        err_next.spd_err_a = 17'(smp.right_count) + 17'(smp.target_speed);
        err_next.spd_err_b = 17'(smp.left_count) + 17'(smp.target_speed);
        err_next.trn_err   = 18'(smp.left_count) - 18'(smp.right_count)
                           + 18'(smp.turn_command);

        // Motor A pass first, then motor B pass on the updated integral
        spd_sum_a          = 19'(spd_int_reg) + 19'(err_next.spd_err_a);
        err_next.spd_int_a = clamp_int(spd_sum_a);
        spd_sum_b          = 19'(err_next.spd_int_a) + 19'(err_next.spd_err_b);
        err_next.spd_int_b = clamp_int(spd_sum_b);

        trn_sum_a          = 19'(trn_int_reg) + 19'(err_next.trn_err);
        err_next.trn_int_a = clamp_int(trn_sum_a);
        trn_sum_b          = 19'(err_next.trn_int_a) + 19'(err_next.trn_err);
        err_next.trn_int_b = clamp_int(trn_sum_b);

        err_next.trip = (smp.filtered_roll >= 17'sd12800)
                     || (smp.filtered_roll <= -17'sd12800);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_int_reg <= '0;
            trn_int_reg <= '0;
        end
        else if (load)
        begin
            spd_int_reg <= err_next.spd_int_b;
            trn_int_reg <= err_next.trn_int_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            err_reg <= err_next;
    end

    assign err = err_reg;

endmodule

`default_nettype wire

// ===== rtl/bpid_mul.sv =====
// Gain multiplier stage: every gain times its error or integral, registered.
`default_nettype none

module bpid_mul
    import bpid_pkg::*;
(
    input  wire logic clk,
    input  wire logic load,
    input  wire cfg_t cfg,
    input  wire err_t err,
    output prod_t     prod
);

    prod_t prod_reg;
    prod_t prod_next;

    logic signed [GAIN_W:0] bkp;
    logic signed [GAIN_W:0] bkd;
    logic signed [GAIN_W:0] skp;
    logic signed [GAIN_W:0] ski;
    logic signed [GAIN_W:0] tkp;
    logic signed [GAIN_W:0] tki;

    always_comb
    begin
        bkp = $signed({1'b0, cfg.balance_kp});
        bkd = $signed({1'b0, cfg.balance_kd});
        skp = $signed({1'b0, cfg.speed_kp});
        ski = $signed({1'b0, cfg.speed_ki});
        tkp = $signed({1'b0, cfg.turn_kp});
        tki = $signed({1'b0, cfg.turn_ki});

        prod_next.bal_p   = 43'(bkp) * 43'(err.roll_err);
        prod_next.bal_d   = 42'(bkd) * 42'(err.gyro_neg);
        prod_next.spd_p_a = 42'(skp) * 42'(err.spd_err_a);
        prod_next.spd_p_b = 42'(skp) * 42'(err.spd_err_b);
        prod_next.spd_i_a = 39'(ski) * 39'(err.spd_int_a);
        prod_next.spd_i_b = 39'(ski) * 39'(err.spd_int_b);
        prod_next.trn_p   = 43'(tkp) * 43'(err.trn_err);
        prod_next.trn_i_a = 39'(tki) * 39'(err.trn_int_a);
        prod_next.trn_i_b = 39'(tki) * 39'(err.trn_int_b);
        prod_next.trip    = err.trip;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/bpid_terms.sv =====
// Term stage: sums the products and rescales them, truncating toward zero.
`default_nettype none

module bpid_terms
    import bpid_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  load,
    input  wire prod_t prod,
    output terms_t     terms
);

    terms_t terms_reg;
    terms_t terms_next;

    logic signed [50:0] bal_sum;
    logic signed [50:0] bal_adj;
    logic signed [42:0] va_sum;
    logic signed [42:0] vb_sum;
    logic signed [42:0] va_adj;
    logic signed [42:0] vb_adj;
    logic signed [43:0] ta_sum;
    logic signed [43:0] tb_sum;
    logic signed [43:0] ta_adj;
    logic signed [43:0] tb_adj;

    always_comb
    begin
        // Balance sum sits at 2^-20; derivative product is at 2^-12
        bal_sum = 51'(prod.bal_p) + (51'(prod.bal_d) <<< 8);
        bal_adj = bal_sum + {31'd0, {20{bal_sum[50]}}};

        va_sum = 43'(prod.spd_p_a) + 43'(prod.spd_i_a);
        vb_sum = 43'(prod.spd_p_b) + 43'(prod.spd_i_b);
        ta_sum = 44'(prod.trn_p) + 44'(prod.trn_i_a);
        tb_sum = 44'(prod.trn_p) + 44'(prod.trn_i_b);

        // Negative values get 2^n - 1 added first so the shift rounds toward zero
        va_adj = va_sum + {31'd0, {12{va_sum[42]}}};
        vb_adj = vb_sum + {31'd0, {12{vb_sum[42]}}};
        ta_adj = ta_sum + {32'd0, {12{ta_sum[43]}}};
        tb_adj = tb_sum + {32'd0, {12{tb_sum[43]}}};

        terms_next.bal  = TERM_W'(bal_adj >>> 20);
        terms_next.va   = TERM_W'(va_adj >>> 12);
        terms_next.vb   = TERM_W'(vb_adj >>> 12);
        terms_next.ta   = TERM_W'(ta_adj >>> 12);
        terms_next.tb   = TERM_W'(tb_adj >>> 12);
        terms_next.trip = prod.trip;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            terms_reg <= terms_next;
    end

    assign terms = terms_reg;

endmodule

`default_nettype wire

// ===== rtl/bpid_drive.sv =====
// Drive stage: combines the terms per motor, clamps and applies the tilt cutoff.
`default_nettype none

module bpid_drive
    import bpid_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          load,
    input  wire cfg_t          cfg,
    input  wire terms_t        terms,
    output logic signed [15:0] drive_a,
    output logic signed [15:0] drive_b,
    output logic               tilt_trip
);

    logic signed [15:0] drive_a_reg;
    logic signed [15:0] drive_b_reg;
    logic               trip_reg;
    logic signed [15:0] drive_a_next;
    logic signed [15:0] drive_b_next;

    logic signed [SUM_W-1:0] sum_a;
    logic signed [SUM_W-1:0] sum_b;
    logic signed [SUM_W-1:0] lim_pos;
    logic signed [SUM_W-1:0] lim_neg;
    logic signed [SUM_W-1:0] clip_a;
    logic signed [SUM_W-1:0] clip_b;

    function automatic logic signed [SUM_W-1:0] clip(
        input logic signed [SUM_W-1:0] v,
        input logic signed [SUM_W-1:0] hi,
        input logic signed [SUM_W-1:0] lo
    );
        logic signed [SUM_W-1:0] r;
        begin
            r = v;
            if (v > hi)
                r = hi;
            else if (v < lo)
                r = lo;
            clip = r;
        end
    endfunction

    always_comb
    begin
        lim_pos = $signed({{(SUM_W-15){1'b0}}, cfg.pwm_limit});
        lim_neg = -lim_pos;
        sum_a   = SUM_W'(terms.bal) + SUM_W'(terms.va) + SUM_W'(terms.ta);
        sum_b   = SUM_W'(terms.bal) + SUM_W'(terms.vb) - SUM_W'(terms.tb);
        clip_a  = clip(sum_a, lim_pos, lim_neg);
        clip_b  = clip(sum_b, lim_pos, lim_neg);
        if (terms.trip)
        begin
            drive_a_next = '0;
            drive_b_next = '0;
        end
        else
        begin
            drive_a_next = clip_a[15:0];
            drive_b_next = clip_b[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_a_reg <= drive_a_next;
            drive_b_reg <= drive_b_next;
            trip_reg    <= terms.trip;
        end
    end

    assign drive_a   = drive_a_reg;
    assign drive_b   = drive_b_reg;
    assign tilt_trip = trip_reg;

endmodule

`default_nettype wire
